// ===== hdl/tsos_pkg.sv =====
package tsos_pkg;

  localparam int unsigned MAX_INPUTS_DEF = 8;
  localparam int unsigned LANE_CAP       = 8;
  localparam int unsigned SLOT_W         = 48;
  localparam int unsigned IVL_W          = 20;
  localparam int unsigned NIN_W          = 4;
  localparam int unsigned PADDR_W        = 5;

  typedef enum logic [2:0] {
    KIND_PAT   = 3'd0,
    KIND_CAT   = 3'd1,
    KIND_NIT   = 3'd2,
    KIND_SDT   = 3'd3,
    KIND_INPUT = 3'd4,
    KIND_EIT   = 3'd5,
    KIND_NULL  = 3'd6
  } src_kind_t;

  typedef enum logic [2:0] {
    REG_PAT_IVL = 3'd0,
    REG_CAT_IVL = 3'd1,
    REG_NIT_IVL = 3'd2,
    REG_SDT_IVL = 3'd3,
    REG_NINPUTS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       got;
    logic [2:0] pick;
    logic [2:0] ptr_nxt;
    logic [7:0] ended_nxt;
    logic       stop;
  } poll_res_t;

endpackage

// ===== hdl/tsos_in_if.sv =====
interface tsos_in_if;
  logic       valid;
  logic       ready;
  logic       pat_ready;
  logic       cat_ready;
  logic       nit_ready;
  logic       sdt_ready;
  logic [7:0] input_ready_mask;
  logic [7:0] input_ended_mask;
  logic       eit_ready;

  modport source (
    output valid, pat_ready, cat_ready, nit_ready, sdt_ready,
           input_ready_mask, input_ended_mask, eit_ready,
    input  ready
  );
  modport sink (
    input  valid, pat_ready, cat_ready, nit_ready, sdt_ready,
           input_ready_mask, input_ended_mask, eit_ready,
    output ready
  );
endinterface

// ===== hdl/tsos_out_if.sv =====
interface tsos_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  source_kind;
  logic [2:0]  chosen_input;
  logic [47:0] slot_number;
  logic        stopped;

  modport source (
    output valid, source_kind, chosen_input, slot_number, stopped,
    input  ready
  );
  modport sink (
    input  valid, source_kind, chosen_input, slot_number, stopped,
    output ready
  );
endinterface

// ===== hdl/ts_output_slot_scheduler_unit.sv =====
// Output slot scheduler: each item accepted on in_ch yields one result on out_ch naming the
// source of the next transport packet slot (PAT, CAT, NIT, SDT, a polled input, EIT or null).
// One item is taken every clock cycle while out_ch does not stall. An item passes an input
// register and then a result register, from which its result is presented on out_ch.
// A result that is not taken holds the input register; while that register is
// empty it still takes one more item. The table due checks and the round-robin walk over up to
// eight inputs are resolved in the single logic stage between those registers. Interval and
// input-count registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16; write them
// while idle.
module ts_output_slot_scheduler_unit #(
  parameter int unsigned MAX_INPUTS = tsos_pkg::MAX_INPUTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tsos_in_if.sink                       in_ch,
  tsos_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsos_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tsos_pkg::*;

  localparam int unsigned LANES = (MAX_INPUTS < LANE_CAP) ? MAX_INPUTS : LANE_CAP;

  // configuration
  logic [IVL_W-1:0] pat_ivl_r, cat_ivl_r, nit_ivl_r, sdt_ivl_r;
  logic [NIN_W-1:0] ninputs_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // scheduler state
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] pat_due_r, cat_due_r, nit_due_r, sdt_due_r;
  logic [SLOT_W-1:0] pat_due_nxt, cat_due_nxt, nit_due_nxt, sdt_due_nxt;
  logic [2:0]        ptr_r, ptr_nxt;
  logic [7:0]        ended_r, ended_nxt;
  logic              stop_r, stop_nxt;

  // input register
  logic       s1_valid_r;
  logic       s1_pat_r, s1_cat_r, s1_nit_r, s1_sdt_r, s1_eit_r;
  logic [7:0] s1_rdy_r, s1_end_r;

  // result register
  logic              out_valid_r;
  src_kind_t         out_kind_r, out_kind_nxt;
  logic [2:0]        out_pick_r, out_pick_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_stop_r;

  logic             adv, run, take;
  logic [NIN_W-1:0] lane_count;
  logic             pat_hit, cat_hit, nit_hit, sdt_hit, poll_en;
  poll_res_t        poll;

  assign adv  = !out_valid_r || out_ch.ready;
  assign run  = s1_valid_r && adv;
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_PAT_IVL: prdata = 32'(pat_ivl_r);
      REG_CAT_IVL: prdata = 32'(cat_ivl_r);
      REG_NIT_IVL: prdata = 32'(nit_ivl_r);
      REG_SDT_IVL: prdata = 32'(sdt_ivl_r);
      REG_NINPUTS: prdata = 32'(ninputs_r);
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_ivl_r <= '0;
      cat_ivl_r <= '0;
      nit_ivl_r <= '0;
      sdt_ivl_r <= '0;
      ninputs_r <= NIN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAT_IVL: pat_ivl_r <= pwdata[IVL_W-1:0];
        REG_CAT_IVL: cat_ivl_r <= pwdata[IVL_W-1:0];
        REG_NIT_IVL: nit_ivl_r <= pwdata[IVL_W-1:0];
        REG_SDT_IVL: sdt_ivl_r <= pwdata[IVL_W-1:0];
        REG_NINPUTS: ninputs_r <= pwdata[NIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the input count to 1 .. LANES
  always_comb begin
    if (ninputs_r == '0) begin
      lane_count = NIN_W'(1);
    end else if (ninputs_r > NIN_W'(LANES)) begin
      lane_count = NIN_W'(LANES);
    end else begin
      lane_count = ninputs_r;
    end
  end

  tsos_poll #(.LANES(LANES)) u_poll (
    .lane_count  (lane_count),
    .poll_ptr    (ptr_r),
    .ended_marks (ended_r),
    .ready_mask  (s1_rdy_r),
    .ended_mask  (s1_end_r),
    .res         (poll)
  );

  assign pat_hit = !stop_r && (slot_r >= pat_due_r) && s1_pat_r;
  assign cat_hit = !stop_r && !pat_hit && (slot_r >= cat_due_r) && s1_cat_r;
  assign nit_hit = !stop_r && !pat_hit && !cat_hit && (slot_r >= nit_due_r) && s1_nit_r;
  assign sdt_hit = !stop_r && !pat_hit && !cat_hit && !nit_hit
                   && (slot_r >= sdt_due_r) && s1_sdt_r;
  assign poll_en = !stop_r && !pat_hit && !cat_hit && !nit_hit && !sdt_hit;

  assign pat_due_nxt = pat_hit ? pat_due_r + SLOT_W'(pat_ivl_r) : pat_due_r;
  assign cat_due_nxt = cat_hit ? cat_due_r + SLOT_W'(cat_ivl_r) : cat_due_r;
  assign nit_due_nxt = nit_hit ? nit_due_r + SLOT_W'(nit_ivl_r) : nit_due_r;
  assign sdt_due_nxt = sdt_hit ? sdt_due_r + SLOT_W'(sdt_ivl_r) : sdt_due_r;
  assign ptr_nxt     = poll_en ? poll.ptr_nxt   : ptr_r;
  assign ended_nxt   = poll_en ? poll.ended_nxt : ended_r;
  assign stop_nxt    = stop_r || (poll_en && poll.stop);
  assign slot_nxt    = slot_r + SLOT_W'(1);

  always_comb begin
    out_pick_nxt = 3'd0;
    priority if (stop_r) begin
      out_kind_nxt = KIND_NULL;
    end else if (pat_hit) begin
      out_kind_nxt = KIND_PAT;
    end else if (cat_hit) begin
      out_kind_nxt = KIND_CAT;
    end else if (nit_hit) begin
      out_kind_nxt = KIND_NIT;
    end else if (sdt_hit) begin
      out_kind_nxt = KIND_SDT;
    end else if (poll.got) begin
      out_kind_nxt = KIND_INPUT;
      out_pick_nxt = poll.pick;
    end else if (s1_eit_r) begin
      out_kind_nxt = KIND_EIT;
    end else begin
      out_kind_nxt = KIND_NULL;
    end
  end

  // state advances only when the held item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      pat_due_r <= '0;
      cat_due_r <= '0;
      nit_due_r <= '0;
      sdt_due_r <= '0;
      ptr_r     <= '0;
      ended_r   <= '0;
      stop_r    <= 1'b0;
    end else if (run) begin
      slot_r    <= slot_nxt;
      pat_due_r <= pat_due_nxt;
      cat_due_r <= cat_due_nxt;
      nit_due_r <= nit_due_nxt;
      sdt_due_r <= sdt_due_nxt;
      ptr_r     <= ptr_nxt;
      ended_r   <= ended_nxt;
      stop_r    <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pat_r <= in_ch.pat_ready;
      s1_cat_r <= in_ch.cat_ready;
      s1_nit_r <= in_ch.nit_ready;
      s1_sdt_r <= in_ch.sdt_ready;
      s1_eit_r <= in_ch.eit_ready;
      s1_rdy_r <= in_ch.input_ready_mask;
      s1_end_r <= in_ch.input_ended_mask;
    end
    if (run) begin
      out_kind_r <= out_kind_nxt;
      out_pick_r <= out_pick_nxt;
      out_slot_r <= slot_r;
      out_stop_r <= stop_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.source_kind  = out_kind_r;
  assign out_ch.chosen_input = out_pick_r;
  assign out_ch.slot_number  = out_slot_r;
  assign out_ch.stopped      = out_stop_r;

  // once set, the stop flag holds until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("stop flag cleared without reset");

  // a stopped slot can only fall to EIT or null
  a_stop_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_r) |->
      (out_kind_r == KIND_EIT || out_kind_r == KIND_NULL))
    else $error("slot issued from a live source after stop");

  // the slot counter moves by one for each issued slot
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    run |=> (slot_r == $past(slot_r) + SLOT_W'(1)))
    else $error("slot counter skipped");

  // a stall holds the input register and the scheduler state
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(slot_r) && $stable(ptr_r)))
    else $error("state moved during a stall");

  // chosen input only names an input slot, and lies within the inputs in use
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (run && out_kind_nxt == KIND_INPUT) |-> ({1'b0, out_pick_nxt} < lane_count))
    else $error("chosen input outside the inputs in use");

endmodule

// ===== hdl/tsos_poll.sv =====
module tsos_poll #(
  parameter int unsigned LANES = tsos_pkg::LANE_CAP
) (
  input  logic [tsos_pkg::NIN_W-1:0] lane_count,
  input  logic [2:0]                 poll_ptr,
  input  logic [7:0]                 ended_marks,
  input  logic [7:0]                 ready_mask,
  input  logic [7:0]                 ended_mask,
  output tsos_pkg::poll_res_t        res
);
  import tsos_pkg::*;

  logic [7:0] inuse;
  logic [3:0] start;
  logic [3:0] idx;
  logic [3:0] last;
  logic [3:0] after;
  logic [7:0] marks;
  logic       done;

  assign inuse = 8'((9'd1 << lane_count) - 9'd1);
  assign start = ({1'b0, poll_ptr} < lane_count) ? {1'b0, poll_ptr} : 4'd0;

  // Walk the inputs in turn from the pointer; stop at a packet or when all are marked.
  always_comb begin
    marks    = ended_marks;
    done     = 1'b0;
    last     = start;
    idx      = start;
    res.got  = 1'b0;
    res.pick = 3'd0;
    res.stop = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      if (!done && (4'(k) < lane_count)) begin
        idx = start + 4'(k);
        if (idx >= lane_count) begin
          idx = idx - lane_count;
        end
        last = idx;
        if (ready_mask[idx[2:0]]) begin
          res.got  = 1'b1;
          res.pick = idx[2:0];
          done     = 1'b1;
        end else if (ended_mask[idx[2:0]]) begin
          marks[idx[2:0]] = 1'b1;
          if ((marks & inuse) == inuse) begin
            res.stop = 1'b1;
            done     = 1'b1;
          end
        end
      end
    end
    after         = last + 4'd1;
    res.ptr_nxt   = (after == lane_count) ? 3'd0 : after[2:0];
    res.ended_nxt = marks;
  end

endmodule
